### rtl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the point-in-triangle test
// Dot product and wide product slot names, stage load enables, pipe depth.
// ----------------------------------------------------------------------------
package pit_pkg;

    // slots of the five dot products
    localparam int DOT_00 = 0;
    localparam int DOT_01 = 1;
    localparam int DOT_02 = 2;
    localparam int DOT_11 = 3;
    localparam int DOT_12 = 4;
    localparam int DOT_N  = 5;

    // slots of the six wide products (p minus q forms det, nu and nv)
    localparam int PROD_DET_P = 0;
    localparam int PROD_DET_Q = 1;
    localparam int PROD_NU_P  = 2;
    localparam int PROD_NU_Q  = 3;
    localparam int PROD_NV_P  = 4;
    localparam int PROD_NV_Q  = 5;
    localparam int PROD_N     = 6;

    // register stages from input word to result word
    localparam int PIPE_DEPTH = 8;

    // load enables of the two stages of a split multiplier
    typedef struct packed {
        logic load_part;
        logic load_prod;
    } stage_en_t;

endpackage

### rtl/pit_if.sv
// ----------------------------------------------------------------------------
// pit_if: channel interfaces of the point-in-triangle test
// Query channel carries one triangle and one point, result channel two flags.
// ----------------------------------------------------------------------------
interface pit_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
               query_x, query_y, query_z,
        input  ready
    );

    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z,
               vertex_b_x, vertex_b_y, vertex_b_z,
               vertex_c_x, vertex_c_y, vertex_c_z,
               query_x, query_y, query_z,
        output ready
    );
endinterface

interface pit_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic degenerate;

    modport source (
        output valid, inside_res, degenerate,
        input  ready
    );

    modport sink (
        input  valid, inside_res, degenerate,
        output ready
    );
endinterface

### rtl/point_in_triangle_test.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test: barycentric point-in-triangle test
// Exact integer test of a 3D point against a triangle, one word per cycle when the result does not stall.
//
//   channel  | dir | word contents
//   ---------+-----+----------------------------------------------------
//   query    | in  | vertices a, b, c and point p, COORD_BITS each axis
//   result   | out | inside_res, degenerate
//
// One query word is taken every cycle unless a result stall backs up to the
// input. A query passes through eight register stages: edge subtract, axis
// multiply, dot sum, partial products, product combine, determinant,
// numerator sum and final compare. Reset clears only the stage valid bits.
// A stalled result holds each full stage; empty stages still fill behind it.
// ----------------------------------------------------------------------------
module point_in_triangle_test #(
    parameter int COORD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pit_in_if.sink     query,
    pit_out_if.source  result
);
    localparam int SW = 2 * COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] va [3];
    logic signed [COORD_BITS-1:0] vb [3];
    logic signed [COORD_BITS-1:0] vc [3];
    logic signed [COORD_BITS-1:0] vq [3];

    logic                 mid_valid;
    logic                 mid_ready;
    logic signed [SW-1:0] dot [pit_pkg::DOT_N];

    // coordinate vectors from the query word
    assign va[0] = query.vertex_a_x;
    assign va[1] = query.vertex_a_y;
    assign va[2] = query.vertex_a_z;
    assign vb[0] = query.vertex_b_x;
    assign vb[1] = query.vertex_b_y;
    assign vb[2] = query.vertex_b_z;
    assign vc[0] = query.vertex_c_x;
    assign vc[1] = query.vertex_c_y;
    assign vc[2] = query.vertex_c_z;
    assign vq[0] = query.query_x;
    assign vq[1] = query.query_y;
    assign vq[2] = query.query_z;

    // edge vectors and dot products
    pit_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .va        (va),
        .vb        (vb),
        .vc        (vc),
        .vq        (vq),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .dot       (dot)
    );

    // wide products and decision
    pit_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .dot        (dot),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .inside_res (result.inside_res),
        .degenerate (result.degenerate)
    );

endmodule

### rtl/pit_front.sv
// ----------------------------------------------------------------------------
// pit_front: edge vectors and dot products
// Three stages: subtract, per-axis multiply, sum of three into five dots.
// ----------------------------------------------------------------------------
module pit_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] va [3],
    input  logic signed [COORD_BITS-1:0] vb [3],
    input  logic signed [COORD_BITS-1:0] vc [3],
    input  logic signed [COORD_BITS-1:0] vq [3],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [2*COORD_BITS+3:0] dot [pit_pkg::DOT_N]
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int SW = 2 * COORD_BITS + 4;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [DW-1:0] e0_next [3];
    logic signed [DW-1:0] e1_next [3];
    logic signed [DW-1:0] w_next  [3];
    logic signed [DW-1:0] e0_reg  [3];
    logic signed [DW-1:0] e1_reg  [3];
    logic signed [DW-1:0] w_reg   [3];

    logic signed [PW-1:0] pr_next [3][pit_pkg::DOT_N];
    logic signed [PW-1:0] pr_reg  [3][pit_pkg::DOT_N];

    logic signed [SW-1:0] dot_next [pit_pkg::DOT_N];
    logic signed [SW-1:0] dot_reg  [pit_pkg::DOT_N];

    // a stage loads when empty or when its successor moves on
    assign en3       = !v3_reg || out_ready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: edge vectors relative to vertex a
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e0_next[i] = {vc[i][COORD_BITS-1], vc[i]} - {va[i][COORD_BITS-1], va[i]};
            e1_next[i] = {vb[i][COORD_BITS-1], vb[i]} - {va[i][COORD_BITS-1], va[i]};
            w_next[i]  = {vq[i][COORD_BITS-1], vq[i]} - {va[i][COORD_BITS-1], va[i]};
        end
    end

    // stage 2: per-axis products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr_next[i][pit_pkg::DOT_00] = e0_reg[i] * e0_reg[i];
            pr_next[i][pit_pkg::DOT_01] = e0_reg[i] * e1_reg[i];
            pr_next[i][pit_pkg::DOT_02] = e0_reg[i] * w_reg[i];
            pr_next[i][pit_pkg::DOT_11] = e1_reg[i] * e1_reg[i];
            pr_next[i][pit_pkg::DOT_12] = e1_reg[i] * w_reg[i];
        end
    end

    // stage 3: sum the three axes
    always_comb
    begin
        for (int k = 0; k < pit_pkg::DOT_N; k++)
        begin
            dot_next[k] = $signed({{2{pr_reg[0][k][PW-1]}}, pr_reg[0][k]})
                        + $signed({{2{pr_reg[1][k][PW-1]}}, pr_reg[1][k]})
                        + $signed({{2{pr_reg[2][k][PW-1]}}, pr_reg[2][k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            w_reg  <= w_next;
        end
        if (en2)
        begin
            pr_reg <= pr_next;
        end
        if (en3)
        begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

### rtl/pit_wmul.sv
// ----------------------------------------------------------------------------
// pit_wmul: two-stage split signed multiplier
// Operands are cut in halves; four partial products, then one combining add.
// ----------------------------------------------------------------------------
module pit_wmul #(
    parameter int OPW = 36
) (
    input  logic                    clk,
    input  pit_pkg::stage_en_t      en,
    input  logic signed [OPW-1:0]   x,
    input  logic signed [OPW-1:0]   y,
    output logic [2*OPW-1:0]        p
);
    localparam int LW = OPW / 2;
    localparam int HW = OPW - LW;
    localparam int MW = 2 * OPW;

    logic signed [HW-1:0]    x_hi, y_hi;
    logic [LW-1:0]           x_lo, y_lo;

    logic signed [2*HW-1:0]  hh_next, hh_reg;
    logic signed [HW+LW:0]   hl_next, hl_reg;
    logic signed [HW+LW:0]   lh_next, lh_reg;
    logic [2*LW-1:0]         ll_next, ll_reg;

    logic signed [HW+LW+1:0] mid;
    logic [MW-1:0]           p_next, p_reg;

    // split: signed upper half, unsigned lower half
    assign x_hi = x[OPW-1:LW];
    assign y_hi = y[OPW-1:LW];
    assign x_lo = x[LW-1:0];
    assign y_lo = y[LW-1:0];

    // partial products
    always_comb
    begin
        hh_next = x_hi * y_hi;
        hl_next = x_hi * $signed({1'b0, y_lo});
        lh_next = y_hi * $signed({1'b0, x_lo});
        ll_next = x_lo * y_lo;
    end

    // weighted sum of partials, modulo 2^MW
    always_comb
    begin
        mid    = hl_reg + lh_reg;
        p_next = {hh_reg, {(2*LW){1'b0}}}
               + {{(HW-2){mid[HW+LW+1]}}, mid, {LW{1'b0}}}
               + {{(2*HW){1'b0}}, ll_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en.load_part)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (en.load_prod)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### rtl/pit_back.sv
// ----------------------------------------------------------------------------
// pit_back: determinant, numerators and inside decision
// Two multiply stages, then determinant, numerator sum and final compare.
// ----------------------------------------------------------------------------
module pit_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [2*COORD_BITS+3:0] dot [pit_pkg::DOT_N],
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           inside_res,
    output logic                           degenerate
);
    localparam int SW = 2 * COORD_BITS + 4;
    localparam int MW = 2 * SW;
    localparam int RW = MW + 1;
    localparam int NW = MW + 2;
    localparam int TW = MW + 3;

    logic v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic en4, en5, en6, en7, en8;
    pit_pkg::stage_en_t mul_en;

    logic signed [SW-1:0] mx [pit_pkg::PROD_N];
    logic signed [SW-1:0] my [pit_pkg::PROD_N];
    logic [MW-1:0]        mp [pit_pkg::PROD_N];

    logic [RW-1:0] det_next, det_reg;
    logic [RW-1:0] nu_next, nu_reg;
    logic [RW-1:0] nv_next, nv_reg;

    logic [RW-1:0] det7_next, det7_reg;
    logic [NW-1:0] nsum_next, nsum_reg;
    logic          nneg_next, nneg_reg;

    logic [TW-1:0] rest;
    logic          inside_next, inside_reg;
    logic          degen_next, degen_reg;

    // stage enables, same rule as the front
    assign en8       = !v8_reg || out_ready;
    assign en7       = !v7_reg || en8;
    assign en6       = !v6_reg || en7;
    assign en5       = !v5_reg || en6;
    assign en4       = !v4_reg || en5;
    assign in_ready  = en4;
    assign out_valid = v8_reg;

    assign mul_en.load_part = en4;
    assign mul_en.load_prod = en5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                v4_reg <= in_valid;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
            if (en8)
            begin
                v8_reg <= v7_reg;
            end
        end
    end

    // operand pairs of the six wide products
    assign mx[pit_pkg::PROD_DET_P] = dot[pit_pkg::DOT_00];
    assign my[pit_pkg::PROD_DET_P] = dot[pit_pkg::DOT_11];
    assign mx[pit_pkg::PROD_DET_Q] = dot[pit_pkg::DOT_01];
    assign my[pit_pkg::PROD_DET_Q] = dot[pit_pkg::DOT_01];
    assign mx[pit_pkg::PROD_NU_P]  = dot[pit_pkg::DOT_11];
    assign my[pit_pkg::PROD_NU_P]  = dot[pit_pkg::DOT_02];
    assign mx[pit_pkg::PROD_NU_Q]  = dot[pit_pkg::DOT_01];
    assign my[pit_pkg::PROD_NU_Q]  = dot[pit_pkg::DOT_12];
    assign mx[pit_pkg::PROD_NV_P]  = dot[pit_pkg::DOT_00];
    assign my[pit_pkg::PROD_NV_P]  = dot[pit_pkg::DOT_12];
    assign mx[pit_pkg::PROD_NV_Q]  = dot[pit_pkg::DOT_01];
    assign my[pit_pkg::PROD_NV_Q]  = dot[pit_pkg::DOT_02];

    // stages 4 and 5: split multipliers
    for (genvar g = 0; g < pit_pkg::PROD_N; g++)
    begin : g_mul
        pit_wmul #(
            .OPW (SW)
        ) u_wmul (
            .clk (clk),
            .en  (mul_en),
            .x   (mx[g]),
            .y   (my[g]),
            .p   (mp[g])
        );
    end

    // stage 6: determinant and the two numerators
    always_comb
    begin
        det_next = {mp[pit_pkg::PROD_DET_P][MW-1], mp[pit_pkg::PROD_DET_P]}
                 - {mp[pit_pkg::PROD_DET_Q][MW-1], mp[pit_pkg::PROD_DET_Q]};
        nu_next  = {mp[pit_pkg::PROD_NU_P][MW-1], mp[pit_pkg::PROD_NU_P]}
                 - {mp[pit_pkg::PROD_NU_Q][MW-1], mp[pit_pkg::PROD_NU_Q]};
        nv_next  = {mp[pit_pkg::PROD_NV_P][MW-1], mp[pit_pkg::PROD_NV_P]}
                 - {mp[pit_pkg::PROD_NV_Q][MW-1], mp[pit_pkg::PROD_NV_Q]};
    end

    // stage 7: nu + nv, and whether either numerator is negative
    always_comb
    begin
        det7_next = det_reg;
        nsum_next = {nu_reg[RW-1], nu_reg} + {nv_reg[RW-1], nv_reg};
        nneg_next = nu_reg[RW-1] || nv_reg[RW-1];
    end

    // stage 8: remainder d - (nu + nv) and the decision
    always_comb
    begin
        rest        = {{2{det7_reg[RW-1]}}, det7_reg} - {nsum_reg[NW-1], nsum_reg};
        degen_next  = (det7_reg == '0);
        inside_next = !degen_next && !det7_reg[RW-1] && !nneg_reg
                   && !rest[TW-1] && (rest != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            det_reg <= det_next;
            nu_reg  <= nu_next;
            nv_reg  <= nv_next;
        end
        if (en7)
        begin
            det7_reg <= det7_next;
            nsum_reg <= nsum_next;
            nneg_reg <= nneg_next;
        end
        if (en8)
        begin
            inside_reg <= inside_next;
            degen_reg  <= degen_next;
        end
    end

    assign inside_res = inside_reg;
    assign degenerate = degen_reg;

endmodule

### rtl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker: port-level assertions for the point-in-triangle test
// Tracks words in flight and checks flow and result consistency.
// ----------------------------------------------------------------------------
module pit_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic inside_res,
    input logic degenerate
);
    localparam int CW = $clog2(pit_pkg::PIPE_DEPTH + 1);

    logic          in_acc, out_acc;
    logic [CW-1:0] cnt_next, cnt_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // words accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // a free-running output never blocks the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // no result without a word in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != '0))
        else $error("result word with nothing in flight");

    // never more words in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(pit_pkg::PIPE_DEPTH))
        else $error("more words in flight than stages");

    // a degenerate triangle is never reported as containing the point
    a_degen_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inside_res && degenerate))
        else $error("inside flagged on degenerate triangle");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res)
                                    && $stable(degenerate))
        else $error("stalled result word changed");

endmodule

bind point_in_triangle_test pit_checker u_pit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .inside_res (result.inside_res),
    .degenerate (result.degenerate)
);
